// ----- hw/rtl/tdma_slot_scheduler_top_defines.svh -----
// Assertion macros for the TDMA slot scheduler.
// Used by the top level; expects clk and rst_n in the scope of each use.
`ifndef TDMA_SLOT_SCHEDULER_TOP_DEFINES_SVH
`define TDMA_SLOT_SCHEDULER_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tss_pkg.sv -----
// Shared types and constants of the TDMA slot scheduler.
// No dependencies; used by every module of the block.
package tss_pkg;

    // Port widths.
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 112;

    // Serial divider step counts.
    localparam int unsigned DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_MOD  = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SLOT = 6'd16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LENGTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_LENGTH    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_COUNT     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_SLOT       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_HELLO_INTERVAL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYNC_HOLDOFF   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RANGING    = 3'd6;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVENT,
        ST_ELAPSED,
        ST_MOD,
        ST_ROLL,
        ST_SLOT,
        ST_RESULT,
        ST_MUL,
        ST_OUT
    } tss_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic apply_events;
        logic hello_check;
        logic div_load_mod;
        logic div_load_slot;
        logic div_step;
        logic roll;
        logic result;
        logic mul;
        logic out_load;
    } tss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic elapsed_ge;
        logic div_done;
        logic out_free;
    } tss_status_t;

endpackage

// ----- hw/rtl/tss_div.sv -----
// Restoring serial divider, one quotient bit per cycle while step is high.
// 32-bit dividend, 16-bit divisor; uses tss_pkg for the step counter width.
module tss_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           step,
    input  logic [31:0]                    dividend,
    input  logic [15:0]                    divisor,
    input  logic [tss_pkg::DIV_CNT_W-1:0]  steps,
    output logic [15:0]                    remainder,
    output logic [15:0]                    quotient,
    output logic                           done
);

    logic [31:0]                   dvd_reg;
    logic [31:0]                   dvd_next;
    logic [15:0]                   rem_reg;
    logic [15:0]                   rem_next;
    logic [15:0]                   dsr_reg;
    logic [tss_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [tss_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [16:0]                   trial;
    logic [16:0]                   diff;
    logic                          fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[31]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[15:0] : trial[15:0];
        dvd_next = {dvd_reg[30:0], fits};
        cnt_next = cnt_reg - {{(tss_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= steps;
        end
        else if (step && !done)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (step && !done)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = (cnt_reg == '0);
    assign remainder = rem_reg;
    assign quotient  = dvd_reg[15:0];

endmodule

// ----- hw/rtl/tss_dp.sv -----
// Datapath of the TDMA slot scheduler: configuration, frame state, result.
// Depends on tss_pkg and instantiates the serial divider tss_div.
module tss_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tss_pkg::tss_cmd_t                  cmd,
    output tss_pkg::tss_status_t               status,
    input  logic [tss_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               cfg_we,
    input  logic [tss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tss_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // Configuration registers.
    logic [15:0] frame_length_reg;
    logic [15:0] slot_length_reg;
    logic [7:0]  slot_count_reg;
    logic [7:0]  own_slot_reg;
    logic [31:0] hello_interval_reg;
    logic [31:0] sync_holdoff_reg;
    logic [15:0] min_ranging_reg;

    // Latched input beat.
    logic [31:0] now_reg;
    logic        sync_req_reg;
    logic [31:0] sync_start_reg;
    logic        hello_sent_reg;
    logic        enter_reg;
    logic        leave_reg;

    // Frame state.
    logic [31:0] frame_start_reg;
    logic [15:0] frame_cnt_reg;
    logic [31:0] last_hello_reg;
    logic [31:0] last_sync_reg;
    logic        hello_due_reg;
    logic        synced_reg;
    logic        resp_reg;
    logic        resp_next;

    // Result pipeline.
    logic [7:0]  slot_reg;
    logic [15:0] remaining_reg;
    logic        own_reg;
    logic [7:0]  ahead_m1_reg;
    logic [23:0] prod_reg;

    // Output register.
    logic                              m_tvalid_reg;
    logic [tss_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;

    // Combinational helpers.
    logic [15:0] fl_eff;
    logic [15:0] sl_eff;
    logic [31:0] since_sync;
    logic [31:0] since_hello;
    logic        sync_ok;
    logic [31:0] elapsed;
    logic        div_load;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic [tss_pkg::DIV_CNT_W-1:0] div_steps;
    logic [15:0] div_rem;
    logic [15:0] div_quo;
    logic        div_done;
    logic [7:0]  slot_sat;
    logic [9:0]  ahead_raw;
    logic [7:0]  ahead_m1;
    logic [31:0] wait_val;
    logic        may_val;
    logic        hello_val;

    // A zero length acts as one.
    assign fl_eff = (frame_length_reg == 16'd0) ? 16'd1 : frame_length_reg;
    assign sl_eff = (slot_length_reg == 16'd0) ? 16'd1 : slot_length_reg;

    // Event decisions.
    assign since_sync  = now_reg - last_sync_reg;
    assign since_hello = now_reg - last_hello_reg;
    assign sync_ok     = sync_req_reg && !(synced_reg && (since_sync < sync_holdoff_reg));
    assign elapsed     = now_reg - frame_start_reg;

    always_comb
    begin
        resp_next = resp_reg;
        if (enter_reg)
        begin
            resp_next = 1'b1;
        end
        if (leave_reg)
        begin
            resp_next = 1'b0;
        end
    end

    // Divider operand selection: frame modulo or slot division.
    always_comb
    begin
        div_load     = cmd.div_load_mod || cmd.div_load_slot;
        div_dividend = elapsed;
        div_divisor  = fl_eff;
        div_steps    = tss_pkg::DIV_STEPS_MOD;
        if (cmd.div_load_slot)
        begin
            div_dividend = {(cmd.roll ? div_rem : elapsed[15:0]), 16'd0};
            div_divisor  = sl_eff;
            div_steps    = tss_pkg::DIV_STEPS_SLOT;
        end
    end

    tss_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .step      (cmd.div_step),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .remainder (div_rem),
        .quotient  (div_quo),
        .done      (div_done)
    );

    // Slot index and the distance to the own slot.
    always_comb
    begin
        slot_sat = (div_quo[15:8] != 8'd0) ? 8'hFF : div_quo[7:0];
        if (own_slot_reg > slot_sat)
        begin
            ahead_raw = {2'b00, own_slot_reg} - {2'b00, slot_sat};
        end
        else
        begin
            ahead_raw = {2'b00, slot_count_reg} - {2'b00, slot_sat} + {2'b00, own_slot_reg};
        end
        // Clamp to at least one slot ahead (two's complement, bit 9 is sign).
        if (ahead_raw[9] || (ahead_raw == 10'd0))
        begin
            ahead_m1 = 8'd0;
        end
        else
        begin
            ahead_m1 = ahead_raw[7:0] - 8'd1;
        end
    end

    // Final result fields.
    assign wait_val  = own_reg ? 32'd0 : ({16'd0, remaining_reg} + {8'd0, prod_reg});
    assign may_val   = !resp_reg && own_reg && (remaining_reg >= min_ranging_reg);
    assign hello_val = hello_due_reg && !resp_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg   <= 16'd1000;
            slot_length_reg    <= 16'd100;
            slot_count_reg     <= 8'd10;
            own_slot_reg       <= 8'd0;
            hello_interval_reg <= 32'd5000;
            sync_holdoff_reg   <= 32'd1000;
            min_ranging_reg    <= 16'd30;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tss_pkg::CFG_FRAME_LENGTH:   frame_length_reg   <= cfg_wdata[15:0];
                tss_pkg::CFG_SLOT_LENGTH:    slot_length_reg    <= cfg_wdata[15:0];
                tss_pkg::CFG_SLOT_COUNT:     slot_count_reg     <= cfg_wdata[7:0];
                tss_pkg::CFG_OWN_SLOT:       own_slot_reg       <= cfg_wdata[7:0];
                tss_pkg::CFG_HELLO_INTERVAL: hello_interval_reg <= cfg_wdata;
                tss_pkg::CFG_SYNC_HOLDOFF:   sync_holdoff_reg   <= cfg_wdata;
                tss_pkg::CFG_MIN_RANGING:    min_ranging_reg    <= cfg_wdata[15:0];
                default:                     ;
            endcase
        end
    end

    // Input beat capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            now_reg        <= s_tdata[31:0];
            sync_req_reg   <= s_tdata[32];
            sync_start_reg <= s_tdata[64:33];
            hello_sent_reg <= s_tdata[65];
            enter_reg      <= s_tdata[66];
            leave_reg      <= s_tdata[67];
        end
    end

    // Frame state: events, hello timer and rollover.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= '0;
            frame_cnt_reg   <= '0;
            last_hello_reg  <= '0;
            last_sync_reg   <= '0;
            hello_due_reg   <= 1'b1;
            synced_reg      <= 1'b0;
            resp_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.apply_events)
            begin
                if (sync_ok)
                begin
                    frame_start_reg <= sync_start_reg;
                    last_sync_reg   <= now_reg;
                    synced_reg      <= 1'b1;
                end
                if (hello_sent_reg)
                begin
                    last_hello_reg <= now_reg;
                    hello_due_reg  <= 1'b0;
                end
                resp_reg <= resp_next;
            end
            if (cmd.hello_check && (since_hello >= hello_interval_reg))
            begin
                hello_due_reg <= 1'b1;
            end
            if (cmd.roll)
            begin
                frame_start_reg <= now_reg - {16'd0, div_rem};
                frame_cnt_reg   <= frame_cnt_reg + 16'd1;
            end
        end
    end

    // Result stages.
    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            slot_reg      <= slot_sat;
            remaining_reg <= sl_eff - div_rem;
            own_reg       <= (slot_sat == own_slot_reg);
            ahead_m1_reg  <= ahead_m1;
        end
        if (cmd.mul)
        begin
            prod_reg <= 24'(ahead_m1_reg) * 24'(sl_eff);
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {4'd0, wait_val, frame_start_reg, frame_cnt_reg, synced_reg,
                            hello_val, may_val, own_reg, remaining_reg, slot_reg};
        end
    end

    assign status.elapsed_ge = (elapsed >= {16'd0, fl_eff});
    assign status.div_done   = div_done;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hw/rtl/tss_ctrl.sv -----
// Controller state machine of the TDMA slot scheduler.
// Depends on tss_pkg; drives the datapath by commands and reads its status.
module tss_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tss_pkg::tss_status_t  status,
    output tss_pkg::tss_cmd_t     cmd
);

    tss_pkg::tss_state_t state_reg;
    tss_pkg::tss_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = tss_pkg::ST_EVENT;
                end
            end
            tss_pkg::ST_EVENT:   state_next = tss_pkg::ST_ELAPSED;
            tss_pkg::ST_ELAPSED:
            begin
                state_next = status.elapsed_ge ? tss_pkg::ST_MOD : tss_pkg::ST_SLOT;
            end
            tss_pkg::ST_MOD:
            begin
                if (status.div_done)
                begin
                    state_next = tss_pkg::ST_ROLL;
                end
            end
            tss_pkg::ST_ROLL:    state_next = tss_pkg::ST_SLOT;
            tss_pkg::ST_SLOT:
            begin
                if (status.div_done)
                begin
                    state_next = tss_pkg::ST_RESULT;
                end
            end
            tss_pkg::ST_RESULT:  state_next = tss_pkg::ST_MUL;
            tss_pkg::ST_MUL:     state_next = tss_pkg::ST_OUT;
            tss_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = tss_pkg::ST_IDLE;
                end
            end
            default:             state_next = tss_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            tss_pkg::ST_EVENT:   cmd.apply_events = 1'b1;
            tss_pkg::ST_ELAPSED:
            begin
                cmd.hello_check   = 1'b1;
                cmd.div_load_mod  = status.elapsed_ge;
                cmd.div_load_slot = !status.elapsed_ge;
            end
            tss_pkg::ST_MOD:     cmd.div_step = 1'b1;
            tss_pkg::ST_ROLL:
            begin
                cmd.roll          = 1'b1;
                cmd.div_load_slot = 1'b1;
            end
            tss_pkg::ST_SLOT:    cmd.div_step = 1'b1;
            tss_pkg::ST_RESULT:  cmd.result   = 1'b1;
            tss_pkg::ST_MUL:     cmd.mul      = 1'b1;
            tss_pkg::ST_OUT:     cmd.out_load = status.out_free;
            default:             cmd          = '0;
        endcase
    end

endmodule

// ----- hw/rtl/tdma_slot_scheduler_top.sv -----
// TDMA slot scheduler, top level: tss_ctrl plus tss_dp, assertion macros from
// tdma_slot_scheduler_top_defines.svh, types from tss_pkg.
//
// Each input beat on the s_ side carries the current millisecond time and the
// event flags; the block applies sync, hello and responding events, rolls the
// frame over and answers with one beat on the m_ side describing the slot.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata; the user is to
// write it only while idle, as the block itself does not enforce this.
// The frame modulo (32 steps), run only on a frame rollover, and the slot
// division (16 steps) share one bit-serial divider.
// One item is in work at a time; the next beat is taken once the result sits
// in the output register.
// If the receiver stalls, the result waits in the output register and the
// block holds its next result until that register frees up.
// Reset clears the frame state, sets the hello as due and loads the default
// configuration (1000 ms frame, 100 ms slots, 10 slots, own slot 0).
module tdma_slot_scheduler_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms[31:0], sync_request[32], sync_frame_start[64:33], hello_sent[65],
    // enter_responding[66], leave_responding[67], zero fill [71:68]
    input  logic [tss_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // slot_idx[7:0], slot_remaining[23:8], in_own_slot[24], may_initiate[25],
    // send_hello[26], is_synced[27], frame_count[43:28], frame_start_time[75:44],
    // wait_until_own_slot[107:76], zero fill [111:108]
    output logic [tss_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [tss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [tss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

`include "tdma_slot_scheduler_top_defines.svh"

    tss_pkg::tss_cmd_t    cmd;
    tss_pkg::tss_status_t status;

    // Controller.
    tss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    tss_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Result fields watched by the checks below.
    logic [15:0] out_remaining;
    logic        out_own;
    logic        out_may;
    logic [31:0] out_wait;

    assign out_remaining = m_tdata[23:8];
    assign out_own       = m_tdata[24];
    assign out_may       = m_tdata[25];
    assign out_wait      = m_tdata[107:76];

    `TSS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
    `TSS_ASSERT_SAME(a_own_wait, m_tvalid && out_own, out_wait == 32'd0, "own slot with wait")
    `TSS_ASSERT_SAME(a_may_own, m_tvalid && out_may, out_own, "ranging outside own slot")
    `TSS_ASSERT_SAME(a_remain, m_tvalid, out_remaining != 16'd0, "slot remaining is zero")

endmodule
